### hw/rtl/a2e_pkg.sv
// ----------------------------------------------------------------------------
// a2e_pkg
// Shared constants for the world-to-observer pose transform: CORDIC gain
// compensation, arctangent table and internal angle format.
// ----------------------------------------------------------------------------
package a2e_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ZW         = 32;
    localparam int MAX_STEPS  = 24;
    localparam int GAIN_SHIFT = 30 - FRAC_BITS;

    localparam logic signed [31:0] GAIN_Q30 = 32'sh26DD_3B6A;

    localparam logic [ZW-1:0] QUARTER_HALF = 32'h2000_0000;

    localparam logic [ZW-1:0] ATAN_TABLE [MAX_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

endpackage

### hw/rtl/allo_to_ego_pose_transform_top.sv
// ----------------------------------------------------------------------------
// allo_to_ego_pose_transform_top
// World-frame target pose to observer-frame pose: offset, CORDIC rotation by
// minus the observer heading, wrapped heading difference.
// ----------------------------------------------------------------------------
// One item in, one item out, one item per cycle when the output is taken.
// The stages are offset subtract, gain multiply, quarter-turn fold, one
// register per CORDIC rotation step, then round and saturate into the
// output register. Each stage holds its item on a stall and empty stages
// fill up, so o_ready stays high while any stage is free.
module allo_to_ego_pose_transform_top
    import a2e_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic [ANGLE_WIDTH-1:0]        i_target_heading,
    input  logic signed [COORD_WIDTH-1:0] i_observer_x,
    input  logic signed [COORD_WIDTH-1:0] i_observer_y,
    input  logic [ANGLE_WIDTH-1:0]        i_observer_heading,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH+1:0] o_rel_x,
    output logic signed [COORD_WIDTH+1:0] o_rel_y,
    output logic [ANGLE_WIDTH-1:0]        o_rel_heading
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int W  = COORD_WIDTH + FRAC_BITS + 3;
    localparam int PW = COORD_WIDTH + 33;
    localparam int RW = W - FRAC_BITS;
    localparam int OW = COORD_WIDTH + 2;
    localparam int HW = ANGLE_WIDTH;
    localparam int N  = CORDIC_STEPS;

    // stage 1: offsets, angle, heading difference
    logic                 r1_v;
    logic signed [DW-1:0] r1_dx, r1_dy;
    logic [ZW-1:0]        r1_z;
    logic [HW-1:0]        r1_hdg;
    logic                 w_en1;
    logic [ZW-1:0]        w_zin;

    // stage 2: gain-compensated offsets, quadrant split
    logic                 r2_v;
    logic signed [W-1:0]  r2_x, r2_y;
    t_quad                r2_quad;
    logic signed [ZW-1:0] r2_rem;
    logic [HW-1:0]        r2_hdg;
    logic                 w_en2;
    logic signed [PW-1:0] w_px, w_py;
    logic [ZW-1:0]        w_zq;
    t_quad                w_quad;

    // stage 3: quarter-turn fold
    logic                 r3_v;
    logic signed [W-1:0]  r3_x, r3_y, n3_x, n3_y;
    logic signed [ZW-1:0] r3_rem;
    logic [HW-1:0]        r3_hdg;
    logic                 w_en3;

    // CORDIC chain
    logic                 c_v   [N+1];
    logic                 c_rdy [N+1];
    logic signed [W-1:0]  c_x   [N+1];
    logic signed [W-1:0]  c_y   [N+1];
    logic signed [ZW-1:0] c_z   [N+1];
    logic [HW-1:0]        c_h   [N+1];

    // output stage
    logic                 r_ov;
    logic signed [OW-1:0] r_rx, r_ry;
    logic [HW-1:0]        r_rh;
    logic                 w_eno;
    logic signed [W-1:0]  w_sx, w_sy;
    logic signed [RW-1:0] w_qx, w_qy;
    logic signed [OW-1:0] n_rx, n_ry;

    assign w_eno    = !r_ov || i_ready;
    assign c_rdy[N] = w_eno;
    assign w_en3    = !r3_v || c_rdy[0];
    assign w_en2    = !r2_v || w_en3;
    assign w_en1    = !r1_v || w_en2;
    assign o_ready  = w_en1;

    assign w_zin = ZW'(0) - {i_observer_heading, {(ZW-HW){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_v <= i_valid;
            end
            if (w_en2) begin
                r2_v <= r1_v;
            end
            if (w_en3) begin
                r3_v <= r2_v;
            end
            if (w_eno) begin
                r_ov <= c_v[N];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_dx  <= DW'(i_target_x) - DW'(i_observer_x);
            r1_dy  <= DW'(i_target_y) - DW'(i_observer_y);
            r1_z   <= w_zin;
            r1_hdg <= i_target_heading - i_observer_heading;
        end
    end

    assign w_px   = PW'(r1_dx) * PW'(GAIN_Q30);
    assign w_py   = PW'(r1_dy) * PW'(GAIN_Q30);
    assign w_zq   = r1_z + QUARTER_HALF;
    assign w_quad = t_quad'(w_zq[ZW-1:ZW-2]);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_x    <= w_px[W+GAIN_SHIFT-1:GAIN_SHIFT];
            r2_y    <= w_py[W+GAIN_SHIFT-1:GAIN_SHIFT];
            r2_quad <= w_quad;
            r2_rem  <= signed'(r1_z - {w_quad, {(ZW-2){1'b0}}});
            r2_hdg  <= r1_hdg;
        end
    end

    always_comb begin
        case (r2_quad)
            QUAD_90: begin
                n3_x = -r2_y;
                n3_y = r2_x;
            end
            QUAD_180: begin
                n3_x = -r2_x;
                n3_y = -r2_y;
            end
            QUAD_270: begin
                n3_x = r2_y;
                n3_y = -r2_x;
            end
            default: begin
                n3_x = r2_x;
                n3_y = r2_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_x   <= n3_x;
            r3_y   <= n3_y;
            r3_rem <= r2_rem;
            r3_hdg <= r2_hdg;
        end
    end

    assign c_v[0] = r3_v;
    assign c_x[0] = r3_x;
    assign c_y[0] = r3_y;
    assign c_z[0] = r3_rem;
    assign c_h[0] = r3_hdg;

    for (genvar k = 0; k < N; k++) begin : g_step
        a2e_cordic_stage #(
            .W    (W),
            .HW   (HW),
            .STEP (k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[k]),
            .o_ready (c_rdy[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .i_hdg   (c_h[k]),
            .o_valid (c_v[k+1]),
            .i_ready (c_rdy[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1]),
            .o_hdg   (c_h[k+1])
        );
    end

    // round half up, then clamp to the output range
    assign w_sx = c_x[N] + W'(1 << (FRAC_BITS - 1));
    assign w_sy = c_y[N] + W'(1 << (FRAC_BITS - 1));
    assign w_qx = w_sx[W-1:FRAC_BITS];
    assign w_qy = w_sy[W-1:FRAC_BITS];

    always_comb begin
        if (w_qx[RW-1] != w_qx[RW-2]) begin
            n_rx = w_qx[RW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end else begin
            n_rx = w_qx[OW-1:0];
        end
        if (w_qy[RW-1] != w_qy[RW-2]) begin
            n_ry = w_qy[RW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end else begin
            n_ry = w_qy[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eno) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rh <= c_h[N];
        end
    end

    assign o_valid       = r_ov;
    assign o_rel_x       = r_rx;
    assign o_rel_y       = r_ry;
    assign o_rel_heading = r_rh;

endmodule

### hw/rtl/a2e_cordic_stage.sv
// ----------------------------------------------------------------------------
// a2e_cordic_stage
// One registered CORDIC rotation step with its own valid bit and
// stall-aware load enable; the heading difference rides along.
// ----------------------------------------------------------------------------
module a2e_cordic_stage
    import a2e_pkg::*;
#(
    parameter int W     = 43,
    parameter int HW    = 16,
    parameter int STEP  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [HW-1:0]        i_hdg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [HW-1:0]        o_hdg
);

    logic                 r_v;
    logic signed [W-1:0]  r_x, n_x;
    logic signed [W-1:0]  r_y, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [HW-1:0]        r_hdg;
    logic                 w_en;
    logic signed [W-1:0]  w_xs;
    logic signed [W-1:0]  w_ys;
    logic signed [ZW-1:0] w_atan;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign w_xs    = i_x >>> STEP;
    assign w_ys    = i_y >>> STEP;
    assign w_atan  = signed'(ATAN_TABLE[STEP]);

    always_comb begin
        if (!i_z[ZW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_atan;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_hdg <= i_hdg;
        end
    end

    assign o_valid = r_v;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_hdg   = r_hdg;

endmodule

### hw/rtl/a2e_checker.sv
// ----------------------------------------------------------------------------
// a2e_checker
// Port-level checks for the pose transform, bound to the top level.
// ----------------------------------------------------------------------------
module a2e_checker #(
    parameter int COORD_WIDTH  = 24,
    parameter int ANGLE_WIDTH  = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [COORD_WIDTH+1:0] o_rel_x,
    input logic signed [COORD_WIDTH+1:0] o_rel_y,
    input logic [ANGLE_WIDTH-1:0]        o_rel_heading
);

    // a result waiting to be taken stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rel_x) && $stable(o_rel_y)
            && $stable(o_rel_heading)))
        else $error("output item changed while stalled");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid)
        else $error("output valid after reset");

    // a free output end means the input side can take an item
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while output side free");

    // straight after reset, an item cannot leave without one having entered
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) && !(i_valid && o_ready)) |=> !o_valid)
        else $error("output item without input item");

endmodule

bind allo_to_ego_pose_transform_top a2e_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH)
) u_a2e_checker (.*);
